// ===== rtl/sfcas_pkg.sv =====
// shared types, codes and constants for the spi fram chunked access sequencer
package sfcas_pkg;

    localparam int CHUNK_BYTES = 32;

    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WRITE = 8'h02;

    localparam logic [1:0] OP_START_READ  = 2'd0;
    localparam logic [1:0] OP_START_WRITE = 2'd1;
    localparam logic [1:0] OP_SLOT        = 2'd2;

    // frame position once the wren frame of a write is stripped off
    localparam logic [2:0] PH_CMD      = 3'd0;
    localparam logic [2:0] PH_ADDR_HI  = 3'd1;
    localparam logic [2:0] PH_ADDR_MID = 3'd2;
    localparam logic [2:0] PH_ADDR_LO  = 3'd3;
    localparam logic [2:0] PH_WREN     = 3'd0;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CLS_START_RD = 2'd0,
        CLS_START_WR = 2'd1,
        CLS_SLOT     = 2'd2,
        CLS_NOP      = 2'd3
    } t_cls;

    typedef enum logic [1:0] {
        ST_SENT     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_BUSY     = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    typedef struct packed {
        t_cls        cls;
        logic [23:0] start_address;
        logic [15:0] length;
        logic [7:0]  write_data;
        logic [7:0]  miso_byte;
    } t_cmd;

    typedef struct packed {
        t_status    status;
        logic [7:0] mosi_byte;
        logic       frame_end;
        logic       read_valid;
        logic [7:0] read_data;
        logic       write_taken;
        logic       done_res;
    } t_result;

endpackage

// ===== rtl/sfcas_in_if.sv =====
// input channel: start items and byte slots
interface sfcas_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [23:0] start_address;
    logic [15:0] length;
    logic [7:0]  write_data;
    logic [7:0]  miso_byte;

    modport source (
        output valid, opcode, start_address, length, write_data, miso_byte,
        input  ready
    );
    modport sink (
        input  valid, opcode, start_address, length, write_data, miso_byte,
        output ready
    );
endinterface

// ===== rtl/sfcas_out_if.sv =====
// output channel: one result beat per input beat
interface sfcas_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] mosi_byte;
    logic       frame_end;
    logic       read_valid;
    logic [7:0] read_data;
    logic       write_taken;
    logic       done_res;

    modport source (
        output valid, status, mosi_byte, frame_end, read_valid, read_data,
               write_taken, done_res,
        input  ready
    );
    modport sink (
        input  valid, status, mosi_byte, frame_end, read_valid, read_data,
               write_taken, done_res,
        output ready
    );
endinterface

// ===== rtl/sfcas_front.sv =====
// front end: takes input beats and classifies the opcode into a command
module sfcas_front (
    sfcas_in_if.sink        i_req,
    output logic            o_cmd_valid,
    output sfcas_pkg::t_cmd o_cmd,
    input  logic            i_cmd_ready
);

    sfcas_pkg::t_cls cls;

    always_comb begin
        case (i_req.opcode)
            sfcas_pkg::OP_START_READ:  cls = sfcas_pkg::CLS_START_RD;
            sfcas_pkg::OP_START_WRITE: cls = sfcas_pkg::CLS_START_WR;
            sfcas_pkg::OP_SLOT:        cls = sfcas_pkg::CLS_SLOT;
            default:                   cls = sfcas_pkg::CLS_NOP;
        endcase
    end

    assign o_cmd_valid          = i_req.valid;
    assign i_req.ready          = i_cmd_ready;
    assign o_cmd.cls            = cls;
    assign o_cmd.start_address  = i_req.start_address;
    assign o_cmd.length         = i_req.length;
    assign o_cmd.write_data     = i_req.write_data;
    assign o_cmd.miso_byte      = i_req.miso_byte;

endmodule

// ===== rtl/sfcas_queue.sv =====
// two-entry command queue between front end and sequencer
module sfcas_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  sfcas_pkg::t_cmd i_push_cmd,
    output logic            o_push_ready,
    output logic            o_pop_valid,
    output sfcas_pkg::t_cmd o_pop_cmd,
    input  logic            i_pop_ready
);

    sfcas_pkg::t_cmd r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/sfcas_back.sv =====
// back end: frame sequencer state and registered result beat
module sfcas_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  sfcas_pkg::t_cmd i_cmd,
    output logic            o_cmd_ready,
    sfcas_out_if.source     o_rsp
);

    sfcas_pkg::t_mode   r_mode, n_mode;
    logic [2:0]         r_phase, n_phase;
    logic [23:0]        r_addr, n_addr;
    logic [15:0]        r_left, n_left;
    logic [7:0]         r_chunk, n_chunk;
    logic               r_out_valid;
    sfcas_pkg::t_result r_res;
    sfcas_pkg::t_result res;

    logic               out_free;
    logic               fire;
    logic               is_write;
    logic [2:0]         p;
    logic [15:0]        left_dec;
    logic [7:0]         chunk_inc;
    logic               finish;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign fire        = i_cmd_valid && out_free;
    assign o_cmd_ready = out_free;

    always_comb begin
        n_mode    = r_mode;
        n_phase   = r_phase;
        n_addr    = r_addr;
        n_left    = r_left;
        n_chunk   = r_chunk;
        res       = '0;
        res.status = sfcas_pkg::ST_IDLE;
        is_write  = (r_mode == sfcas_pkg::MODE_WRITE);
        p         = r_phase - {2'b00, is_write};
        left_dec  = r_left - 16'd1;
        chunk_inc = r_chunk + 8'd1;
        finish    = 1'b0;
        case (i_cmd.cls)
            sfcas_pkg::CLS_START_RD, sfcas_pkg::CLS_START_WR: begin
                if (r_mode != sfcas_pkg::MODE_IDLE) begin
                    res.status = sfcas_pkg::ST_BUSY;
                end else begin
                    res.status = sfcas_pkg::ST_ACCEPTED;
                    n_addr     = i_cmd.start_address;
                    n_left     = i_cmd.length;
                    n_phase    = 3'd0;
                    n_chunk    = 8'd0;
                    n_mode     = (i_cmd.cls == sfcas_pkg::CLS_START_RD) ?
                                 sfcas_pkg::MODE_READ : sfcas_pkg::MODE_WRITE;
                end
            end
            sfcas_pkg::CLS_SLOT: begin
                if (r_mode != sfcas_pkg::MODE_IDLE) begin
                    res.status = sfcas_pkg::ST_SENT;
                    if (is_write && r_phase == sfcas_pkg::PH_WREN) begin
                        // wren is a frame of its own
                        res.mosi_byte = sfcas_pkg::CMD_WREN;
                        res.frame_end = 1'b1;
                        n_phase       = 3'd1;
                    end else begin
                        case (p) inside
                            sfcas_pkg::PH_CMD: begin
                                res.mosi_byte = is_write ? sfcas_pkg::CMD_WRITE
                                                         : sfcas_pkg::CMD_READ;
                                n_phase       = r_phase + 3'd1;
                            end
                            [sfcas_pkg::PH_ADDR_HI:sfcas_pkg::PH_ADDR_LO]: begin
                                case (p)
                                    sfcas_pkg::PH_ADDR_HI:  res.mosi_byte = r_addr[23:16];
                                    sfcas_pkg::PH_ADDR_MID: res.mosi_byte = r_addr[15:8];
                                    default:                res.mosi_byte = r_addr[7:0];
                                endcase
                                // zero length ends the frame after the address
                                if (p == sfcas_pkg::PH_ADDR_LO && r_left == 16'd0) begin
                                    finish = 1'b1;
                                end else begin
                                    n_phase = r_phase + 3'd1;
                                end
                            end
                            default: begin
                                if (is_write) begin
                                    res.mosi_byte   = i_cmd.write_data;
                                    res.write_taken = 1'b1;
                                end else begin
                                    res.read_valid = 1'b1;
                                    res.read_data  = i_cmd.miso_byte;
                                end
                                n_addr  = r_addr + 24'd1;
                                n_left  = left_dec;
                                n_chunk = chunk_inc;
                                if (left_dec == 16'd0 ||
                                    chunk_inc >= 8'(sfcas_pkg::CHUNK_BYTES)) begin
                                    finish = 1'b1;
                                end
                            end
                        endcase
                    end
                    if (finish) begin
                        res.frame_end = 1'b1;
                        n_phase       = 3'd0;
                        n_chunk       = 8'd0;
                        if (n_left == 16'd0) begin
                            res.done_res = 1'b1;
                            n_mode       = sfcas_pkg::MODE_IDLE;
                        end
                    end
                end
            end
            default: begin
                res.status = sfcas_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= sfcas_pkg::MODE_IDLE;
            r_phase     <= 3'd0;
            r_addr      <= 24'd0;
            r_left      <= 16'd0;
            r_chunk     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_mode  <= n_mode;
                r_phase <= n_phase;
                r_addr  <= n_addr;
                r_left  <= n_left;
                r_chunk <= n_chunk;
            end
            if (out_free) begin
                r_out_valid <= i_cmd_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_res.status;
    assign o_rsp.mosi_byte   = r_res.mosi_byte;
    assign o_rsp.frame_end   = r_res.frame_end;
    assign o_rsp.read_valid  = r_res.read_valid;
    assign o_rsp.read_data   = r_res.read_data;
    assign o_rsp.write_taken = r_res.write_taken;
    assign o_rsp.done_res    = r_res.done_res;

    a_done_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.done_res |-> r_res.frame_end)
        else $error("done without frame end");

    a_rd_wr_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.read_valid && r_res.write_taken))
        else $error("read and write data in one beat");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == sfcas_pkg::MODE_IDLE |-> r_phase == 3'd0 && r_chunk == 8'd0)
        else $error("idle with frame position left over");

    a_chunk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chunk < 8'(sfcas_pkg::CHUNK_BYTES))
        else $error("chunk count past chunk size");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_rsp.ready |=> r_out_valid && $stable(r_res))
        else $error("stalled result changed");

endmodule

// ===== rtl/spi_fram_chunked_access_sequencer.sv =====
// top level of the spi fram chunked access sequencer
// usage:
//   i_req carries one beat per item: start read, start write, or one spi
//   byte slot (with the write byte to send and the miso byte sampled in
//   that slot). o_rsp returns exactly one result beat per input beat, in
//   order: status, the mosi byte, frame end (chip select rises after this
//   byte), captured read byte, write byte consumed and transfer done.
//   a read chunk is one frame of READ, three address bytes and up to
//   CHUNK_BYTES data bytes; a write chunk is a WREN frame followed by a
//   WRITE frame of the same shape.
// throughput and pipeline:
//   one beat per cycle sustained while o_rsp is ready; an input beat is first
//   written into the queue, then sits at the queue head while the frame
//   sequencer registers its result into the result register, from which
//   the result handshake is made.
// stalls and reset:
//   when o_rsp stalls the result register holds, the two-entry queue fills
//   and then i_req.ready drops. reset empties the queue and the result
//   register and returns the sequencer to idle.
module spi_fram_chunked_access_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfcas_in_if.sink    i_req,
    sfcas_out_if.source o_rsp
);

    logic            front_valid;
    sfcas_pkg::t_cmd front_cmd;
    logic            front_ready;
    logic            head_valid;
    sfcas_pkg::t_cmd head_cmd;
    logic            head_ready;

    sfcas_front u_front (
        .i_req       (i_req),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    sfcas_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_cmd   (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (head_valid),
        .o_pop_cmd    (head_cmd),
        .i_pop_ready  (head_ready)
    );

    sfcas_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_cmd_ready (head_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== sim/tb_spi_fram_chunked_access_sequencer.sv =====
`timescale 1ns / 1ps
// testbench for the spi fram chunked access sequencer: directed table, random transfers
module tb_spi_fram_chunked_access_sequencer;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 1950;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES = 150;
    localparam sfcas_pkg::t_result NO_RES = '0;

    typedef struct {
        logic [1:0]         op;
        logic [23:0]        addr;
        logic [15:0]        len;
        logic [7:0]         wdata;
        logic [7:0]         miso;
        bit                 typed;
        sfcas_pkg::t_result want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    sfcas_in_if  u_req ();
    sfcas_out_if u_rsp ();

    spi_fram_chunked_access_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .o_rsp   (u_rsp)
    );

    // shadow of the sequencer state
    sfcas_pkg::t_mode fs_mode;
    logic [2:0]       fs_phase;
    logic [23:0]      fs_addr;
    logic [15:0]      fs_left;
    logic [7:0]       fs_chunk;

    sfcas_pkg::t_result pending_rsp[$];
    t_row               dir_rows[$];

    int  n_errors;
    int  n_in;
    int  n_out;
    int  n_active;
    int  n_rd_xfer;
    int  n_wr_xfer;
    int  n_done;
    int  n_frames;
    bit  steady;
    bit  hold_done;

    function automatic sfcas_pkg::t_result fram_seq_next(logic [1:0] op, logic [23:0] a,
                                                         logic [15:0] l, logic [7:0] wd,
                                                         logic [7:0] mi);
        sfcas_pkg::t_result r;
        logic               is_wr;
        logic [2:0]         p;
        logic               close;
        r = '0;
        close = 1'b0;
        if (op == sfcas_pkg::OP_START_READ || op == sfcas_pkg::OP_START_WRITE) begin
            if (fs_mode != sfcas_pkg::MODE_IDLE) begin
                r.status = sfcas_pkg::ST_BUSY;
            end else begin
                fs_addr  = a;
                fs_left  = l;
                fs_phase = '0;
                fs_chunk = '0;
                fs_mode  = (op == sfcas_pkg::OP_START_READ) ? sfcas_pkg::MODE_READ
                                                            : sfcas_pkg::MODE_WRITE;
                r.status = sfcas_pkg::ST_ACCEPTED;
            end
        end else if (op == sfcas_pkg::OP_SLOT && fs_mode != sfcas_pkg::MODE_IDLE) begin
            is_wr = (fs_mode == sfcas_pkg::MODE_WRITE);
            p = fs_phase - {2'b00, is_wr};
            r.status = sfcas_pkg::ST_SENT;
            if (is_wr && fs_phase == sfcas_pkg::PH_WREN) begin
                r.mosi_byte = sfcas_pkg::CMD_WREN;
                r.frame_end = 1'b1;
                fs_phase = 3'd1;
            end else if (p == sfcas_pkg::PH_CMD) begin
                r.mosi_byte = is_wr ? sfcas_pkg::CMD_WRITE : sfcas_pkg::CMD_READ;
                fs_phase = fs_phase + 3'd1;
            end else if (p == sfcas_pkg::PH_ADDR_HI || p == sfcas_pkg::PH_ADDR_MID ||
                         p == sfcas_pkg::PH_ADDR_LO) begin
                case (p)
                    sfcas_pkg::PH_ADDR_HI:  r.mosi_byte = fs_addr[23:16];
                    sfcas_pkg::PH_ADDR_MID: r.mosi_byte = fs_addr[15:8];
                    default:                r.mosi_byte = fs_addr[7:0];
                endcase
                // zero length ends the chunk on the low address byte
                if (p == sfcas_pkg::PH_ADDR_LO && fs_left == 16'd0)
                    close = 1'b1;
                else
                    fs_phase = fs_phase + 3'd1;
            end else begin
                if (is_wr) begin
                    r.mosi_byte   = wd;
                    r.write_taken = 1'b1;
                end else begin
                    r.read_valid = 1'b1;
                    r.read_data  = mi;
                end
                fs_addr  = fs_addr + 24'd1;
                fs_left  = fs_left - 16'd1;
                fs_chunk = fs_chunk + 8'd1;
                if (fs_left == 16'd0 || fs_chunk >= 8'(sfcas_pkg::CHUNK_BYTES))
                    close = 1'b1;
            end
            if (close) begin
                r.frame_end = 1'b1;
                fs_phase = '0;
                fs_chunk = '0;
                if (fs_left == 16'd0) begin
                    r.done_res = 1'b1;
                    fs_mode = sfcas_pkg::MODE_IDLE;
                end
            end
        end else begin
            r.status = sfcas_pkg::ST_IDLE;
        end
        return r;
    endfunction

    function automatic sfcas_pkg::t_result typed_res(sfcas_pkg::t_status s, logic [7:0] mosi,
                                                     logic fe, logic dn);
        sfcas_pkg::t_result r;
        r = '0;
        r.status    = s;
        r.mosi_byte = mosi;
        r.frame_end = fe;
        r.done_res  = dn;
        return r;
    endfunction

    function automatic t_row mk_row(logic [1:0] op, logic [23:0] a, logic [15:0] l,
                                    logic [7:0] wd, logic [7:0] mi, bit typed,
                                    sfcas_pkg::t_result want);
        t_row rw;
        rw.op = op;
        rw.addr = a;
        rw.len = l;
        rw.wdata = wd;
        rw.miso = mi;
        rw.typed = typed;
        rw.want = want;
        return rw;
    endfunction

    function automatic int draw_gap();
        return steady ? 0 : int'($urandom_range(0, 3));
    endfunction

    // offer one beat, wait for the handshake, then predict its result
    task automatic send_beat(logic [1:0] op, logic [23:0] a, logic [15:0] l, logic [7:0] wd,
                             logic [7:0] mi, bit typed, sfcas_pkg::t_result want);
        int                 gap;
        sfcas_pkg::t_result r;
        gap = draw_gap();
        repeat (gap) begin
            @(negedge i_clk);
            u_req.valid <= 1'b0;
        end
        @(negedge i_clk);
        u_req.valid         <= 1'b1;
        u_req.opcode        <= op;
        u_req.start_address <= a;
        u_req.length        <= l;
        u_req.write_data    <= wd;
        u_req.miso_byte     <= mi;
        do @(posedge i_clk); while (!u_req.ready);
        r = fram_seq_next(op, a, l, wd, mi);
        n_in++;
        if (r.status == sfcas_pkg::ST_SENT || r.status == sfcas_pkg::ST_ACCEPTED)
            n_active++;
        if (r.status == sfcas_pkg::ST_ACCEPTED) begin
            if (op == sfcas_pkg::OP_START_READ)
                n_rd_xfer++;
            else
                n_wr_xfer++;
        end
        pending_rsp.push_back(typed ? want : r);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results still outstanding", pending_rsp.size());
        $display("FAIL");
        $finish;
    end

    // result side: random stalls plus one long hold-off
    initial begin
        sfcas_pkg::t_result got;
        sfcas_pkg::t_result exp_r;
        int                 stall;
        u_rsp.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && n_out >= HOLD_AT_RESULT) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(negedge i_clk);
                    u_rsp.ready <= 1'b0;
                end
            end
            stall = draw_gap();
            repeat (stall) begin
                @(negedge i_clk);
                u_rsp.ready <= 1'b0;
            end
            @(negedge i_clk);
            u_rsp.ready <= 1'b1;
            do @(posedge i_clk); while (!u_rsp.valid);
            got.status      = sfcas_pkg::t_status'(u_rsp.status);
            got.mosi_byte   = u_rsp.mosi_byte;
            got.frame_end   = u_rsp.frame_end;
            got.read_valid  = u_rsp.read_valid;
            got.read_data   = u_rsp.read_data;
            got.write_taken = u_rsp.write_taken;
            got.done_res    = u_rsp.done_res;
            n_out++;
            if (got.frame_end === 1'b1)
                n_frames++;
            if (got.done_res === 1'b1)
                n_done++;
            if (pending_rsp.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %0h", $time, got);
                n_errors++;
            end else begin
                exp_r = pending_rsp.pop_front();
                if (got !== exp_r) begin
                    $display("%0t: result mismatch, expected %0h, actual %0h",
                             $time, exp_r, got);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        logic [1:0]  op;
        logic [15:0] len;
        int          n_xfer;
        int          k;

        n_errors = 0; n_in = 0; n_out = 0; n_active = 0;
        n_rd_xfer = 0; n_wr_xfer = 0; n_done = 0; n_frames = 0;
        steady = 1'b0;
        hold_done = 1'b0;
        fs_mode = sfcas_pkg::MODE_IDLE;
        fs_phase = '0; fs_addr = '0; fs_left = '0; fs_chunk = '0;

        i_rst_n = 1'b0;
        u_req.valid = 1'b0;
        u_req.opcode = sfcas_pkg::OP_SLOT;
        u_req.start_address = '0;
        u_req.length = '0;
        u_req.write_data = '0;
        u_req.miso_byte = '0;

        // slot while idle, zero-length read at the top address, busy start, unused opcode
        dir_rows.push_back(mk_row(sfcas_pkg::OP_SLOT, 24'h0, 16'h0, 8'hFF, 8'hFF, 1'b1,
                                  typed_res(sfcas_pkg::ST_IDLE, 8'h00, 1'b0, 1'b0)));
        dir_rows.push_back(mk_row(sfcas_pkg::OP_START_READ, 24'hFFFFFF, 16'h0, 8'h00, 8'h00,
                                  1'b1,
                                  typed_res(sfcas_pkg::ST_ACCEPTED, 8'h00, 1'b0, 1'b0)));
        dir_rows.push_back(mk_row(sfcas_pkg::OP_START_WRITE, 24'h000000, 16'hFFFF, 8'hFF,
                                  8'hFF, 1'b1,
                                  typed_res(sfcas_pkg::ST_BUSY, 8'h00, 1'b0, 1'b0)));
        dir_rows.push_back(mk_row(OP_UNUSED, 24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b1,
                                  typed_res(sfcas_pkg::ST_IDLE, 8'h00, 1'b0, 1'b0)));
        for (k = 0; k < 3; k++)
            dir_rows.push_back(mk_row(sfcas_pkg::OP_SLOT, 24'h0, 16'h0, 8'hFF, 8'hFF, 1'b0,
                                      NO_RES));
        dir_rows.push_back(mk_row(sfcas_pkg::OP_SLOT, 24'h0, 16'h0, 8'hFF, 8'hFF, 1'b1,
                                  typed_res(sfcas_pkg::ST_SENT, 8'hFF, 1'b1, 1'b1)));
        // zero-length write: wren frame, then command and address only
        dir_rows.push_back(mk_row(sfcas_pkg::OP_START_WRITE, 24'h000000, 16'h0, 8'h00, 8'h00,
                                  1'b1,
                                  typed_res(sfcas_pkg::ST_ACCEPTED, 8'h00, 1'b0, 1'b0)));
        for (k = 0; k < 5; k++)
            dir_rows.push_back(mk_row(sfcas_pkg::OP_SLOT, 24'h0, 16'h0, 8'hFF, 8'hFF, 1'b0,
                                      NO_RES));
        // one-byte write at the top address, address wraps
        dir_rows.push_back(mk_row(sfcas_pkg::OP_START_WRITE, 24'hFFFFFF, 16'h1, 8'h00, 8'h00,
                                  1'b1,
                                  typed_res(sfcas_pkg::ST_ACCEPTED, 8'h00, 1'b0, 1'b0)));
        for (k = 0; k < 6; k++)
            dir_rows.push_back(mk_row(sfcas_pkg::OP_SLOT, 24'h0, 16'h0, 8'hFF, 8'h00, 1'b0,
                                      NO_RES));
        // one-byte read at address zero
        dir_rows.push_back(mk_row(sfcas_pkg::OP_START_READ, 24'h000000, 16'h1, 8'h00, 8'h00,
                                  1'b1,
                                  typed_res(sfcas_pkg::ST_ACCEPTED, 8'h00, 1'b0, 1'b0)));
        for (k = 0; k < 5; k++)
            dir_rows.push_back(mk_row(sfcas_pkg::OP_SLOT, 24'h0, 16'h0, 8'h00, 8'hFF, 1'b0,
                                      NO_RES));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_beat(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].len, dir_rows[i].wdata,
                      dir_rows[i].miso, dir_rows[i].typed, dir_rows[i].want);

        n_xfer = 0;
        while (n_in < RANDOM_BEATS) begin
            steady = (n_xfer % 7 == 3);
            // noise between transfers: idle slot or unused opcode
            if ($urandom_range(0, 3) == 0)
                send_beat($urandom_range(0, 1) ? sfcas_pkg::OP_SLOT : OP_UNUSED,
                          24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                          1'b0, NO_RES);
            op = $urandom_range(0, 1) ? sfcas_pkg::OP_START_WRITE : sfcas_pkg::OP_START_READ;
            case ($urandom_range(0, 9))
                0:       len = 16'd0;
                1:       len = 16'($urandom_range(1, 2) * sfcas_pkg::CHUNK_BYTES);
                2:       len = $urandom_range(0, 1) ? 16'(sfcas_pkg::CHUNK_BYTES - 1)
                                                    : 16'(sfcas_pkg::CHUNK_BYTES + 1);
                3, 4, 5, 6: len = 16'($urandom_range(1, 40));
                default: len = 16'($urandom_range(1, 100));
            endcase
            send_beat(op, 24'($urandom), len, 8'($urandom), 8'($urandom), 1'b0, NO_RES);
            while (fs_mode != sfcas_pkg::MODE_IDLE) begin
                if ($urandom_range(0, 15) == 0) begin
                    // busy start with full-range fields, or an unused opcode mid-transfer
                    send_beat($urandom_range(0, 2) == 0 ? OP_UNUSED : 2'($urandom_range(0, 1)),
                              24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                              1'b0, NO_RES);
                end else begin
                    send_beat(sfcas_pkg::OP_SLOT, 24'($urandom), 16'($urandom),
                              8'($urandom), 8'($urandom), 1'b0, NO_RES);
                end
            end
            n_xfer++;
        end
        steady = 1'b0;
        @(negedge i_clk);
        u_req.valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d input beats, %0d result beats: %0d read and %0d write transfers",
                 n_in, n_out, n_rd_xfer, n_wr_xfer);
        $display("%0d frames closed, %0d transfers done, %0d errors", n_frames, n_done, n_errors);
        if (n_errors == 0 && pending_rsp.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/sfcas_pkg.sv
rtl/sfcas_in_if.sv
rtl/sfcas_out_if.sv
rtl/sfcas_front.sv
rtl/sfcas_queue.sv
rtl/sfcas_back.sv
rtl/spi_fram_chunked_access_sequencer.sv
sim/tb_spi_fram_chunked_access_sequencer.sv
